### hdl/flash_wear_level_monitor_unit_defines.svh
// Assertion macros for the flash wear level monitor.
// Self-contained; included by the top level, which checks its own logic.
`ifndef FLASH_WEAR_LEVEL_MONITOR_UNIT_DEFINES_SVH
`define FLASH_WEAR_LEVEL_MONITOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define FWLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwlm check failed");
// Next-cycle implication, checked out of reset.
`define FWLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwlm check failed");
`else
`define FWLM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FWLM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/fwlm_pkg.sv
// Shared constants, state encoding and controller/datapath interface types
// for the flash wear level monitor. No dependencies.
package fwlm_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int BLK_W      = IDX_W + 1;
    localparam int CNT_W      = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX       = 32'hffff_ffff;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 32'd1000;

    // Configuration register indexes
    localparam logic CFG_WEAR_THRESHOLD = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE  = 1'b1;

    // Event codes
    localparam logic ACT_ERASE = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ER_READ,
        ST_ER_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_CALC,
        ST_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic erase_read;
        logic erase_write;
        logic error_set;
        logic scan_init;
        logic scan_read;
        logic final_calc;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic action;
        logic idx_ok;
        logic scan_last;
    } t_dp_stat;

endpackage

### hdl/fwlm_dp.sv
// Datapath of the wear level monitor: config registers, erase counter memory,
// address counter, min/max scan and result registers. Depends on fwlm_pkg.
module fwlm_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [fwlm_pkg::CNT_W-1:0]     i_cfg_data,
    input  logic                           i_action,
    input  logic [fwlm_pkg::IDX_W-1:0]     i_block_index,
    input  fwlm_pkg::t_dp_cmd              i_cmd,
    output fwlm_pkg::t_dp_stat             o_stat,
    output logic [fwlm_pkg::CNT_W-1:0]     o_count_value,
    output logic [fwlm_pkg::CNT_W-1:0]     o_highest_count,
    output logic [fwlm_pkg::IDX_W-1:0]     o_coldest_block,
    output logic                           o_relocate_needed,
    output logic                           o_index_error
);

    localparam int IDX_W = fwlm_pkg::IDX_W;
    localparam int BLK_W = fwlm_pkg::BLK_W;
    localparam int CNT_W = fwlm_pkg::CNT_W;

    logic [CNT_W-1:0] r_wear_threshold;
    logic [BLK_W-1:0] r_blocks_in_use;
    logic [BLK_W-1:0] eff_n;

    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] r_idx;
    logic             r_action;

    logic [CNT_W-1:0] r_mem [fwlm_pkg::MAX_BLOCKS];
    logic [CNT_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [CNT_W-1:0] inc_value;

    logic [CNT_W-1:0] r_hi;
    logic [CNT_W-1:0] r_lo;
    logic [IDX_W-1:0] r_cold;
    logic             r_first;

    logic [CNT_W-1:0] r_count_value;
    logic [CNT_W-1:0] r_highest_count;
    logic [IDX_W-1:0] r_coldest_block;
    logic             r_relocate_needed;
    logic             r_index_error;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wear_threshold <= fwlm_pkg::THRESHOLD_RESET;
            r_blocks_in_use  <= BLK_W'(fwlm_pkg::MAX_BLOCKS);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fwlm_pkg::CFG_WEAR_THRESHOLD: r_wear_threshold <= i_cfg_data;
                fwlm_pkg::CFG_BLOCKS_IN_USE:  r_blocks_in_use  <= i_cfg_data[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective block count: zero reads as one, clamp at the array size
    always_comb begin
        if (r_blocks_in_use == '0) begin
            eff_n = BLK_W'(1);
        end else if (r_blocks_in_use > BLK_W'(fwlm_pkg::MAX_BLOCKS)) begin
            eff_n = BLK_W'(fwlm_pkg::MAX_BLOCKS);
        end else begin
            eff_n = r_blocks_in_use;
        end
    end

    // Address counter, shared by the clearing pass and the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.scan_init) begin
            r_addr <= '0;
        end else if (i_cmd.clear_step || i_cmd.scan_read) begin
            r_addr <= r_addr + IDX_W'(1);
        end
    end

    // Latched event
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_idx    <= i_block_index;
        end
    end

    assign o_stat.clear_last = (r_addr == IDX_W'(fwlm_pkg::MAX_BLOCKS - 1));
    assign o_stat.action     = r_action;
    assign o_stat.idx_ok     = ({1'b0, r_idx} < eff_n);
    assign o_stat.scan_last  = ({1'b0, r_addr} == (eff_n - BLK_W'(1)));

    // Saturating increment of the counter just read
    assign inc_value = (r_rd_data == fwlm_pkg::COUNT_MAX) ? r_rd_data
                                                          : r_rd_data + CNT_W'(1);

    // Memory port selection
    assign mem_we    = i_cmd.clear_step || i_cmd.erase_write;
    assign mem_waddr = i_cmd.clear_step ? r_addr : r_idx;
    assign mem_wdata = i_cmd.clear_step ? '0 : inc_value;
    assign mem_re    = i_cmd.erase_read || i_cmd.scan_read;
    assign mem_raddr = i_cmd.scan_read ? r_addr : r_idx;

    // Erase counter memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Scan read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_read) begin
            r_rd_idx <= r_addr;
        end
    end

    // Running max, min and first index of min
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_hi    <= '0;
            r_lo    <= fwlm_pkg::COUNT_MAX;
            r_cold  <= '0;
            r_first <= 1'b1;
        end else if (r_rd_vld) begin
            if (r_rd_data > r_hi) begin
                r_hi <= r_rd_data;
            end
            if (r_first || (r_rd_data < r_lo)) begin
                r_lo    <= r_rd_data;
                r_cold  <= r_rd_idx;
                r_first <= 1'b0;
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.erase_write) begin
            r_count_value     <= inc_value;
            r_highest_count   <= '0;
            r_coldest_block   <= '0;
            r_relocate_needed <= 1'b0;
            r_index_error     <= 1'b0;
        end else if (i_cmd.error_set) begin
            r_count_value     <= '0;
            r_highest_count   <= '0;
            r_coldest_block   <= '0;
            r_relocate_needed <= 1'b0;
            r_index_error     <= 1'b1;
        end else if (i_cmd.final_calc) begin
            r_count_value     <= r_lo;
            r_highest_count   <= r_hi;
            r_coldest_block   <= r_cold;
            r_relocate_needed <= ((r_hi - r_lo) > r_wear_threshold);
            r_index_error     <= 1'b0;
        end
    end

    assign o_count_value     = r_count_value;
    assign o_highest_count   = r_highest_count;
    assign o_coldest_block   = r_coldest_block;
    assign o_relocate_needed = r_relocate_needed;
    assign o_index_error     = r_index_error;

endmodule

### hdl/fwlm_ctrl.sv
// Controller state machine of the wear level monitor: clearing pass, erase
// and check sequencing, busy and result strobe. Depends on fwlm_pkg.
module fwlm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  fwlm_pkg::t_dp_stat    i_stat,
    output fwlm_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    fwlm_pkg::t_state r_state;
    fwlm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwlm_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fwlm_pkg::ST_CLEAR: begin
                if (i_stat.clear_last) n_state = fwlm_pkg::ST_IDLE;
            end
            fwlm_pkg::ST_IDLE: begin
                if (i_start) n_state = fwlm_pkg::ST_DECODE;
            end
            fwlm_pkg::ST_DECODE: begin
                if (i_stat.action == fwlm_pkg::ACT_CHECK) begin
                    n_state = fwlm_pkg::ST_SCAN;
                end else if (i_stat.idx_ok) begin
                    n_state = fwlm_pkg::ST_ER_READ;
                end else begin
                    n_state = fwlm_pkg::ST_DONE;
                end
            end
            fwlm_pkg::ST_ER_READ:  n_state = fwlm_pkg::ST_ER_WRITE;
            fwlm_pkg::ST_ER_WRITE: n_state = fwlm_pkg::ST_DONE;
            fwlm_pkg::ST_SCAN: begin
                if (i_stat.scan_last) n_state = fwlm_pkg::ST_DRAIN;
            end
            fwlm_pkg::ST_DRAIN: n_state = fwlm_pkg::ST_CALC;
            fwlm_pkg::ST_CALC:  n_state = fwlm_pkg::ST_DONE;
            fwlm_pkg::ST_DONE:  n_state = fwlm_pkg::ST_IDLE;
            default:            n_state = fwlm_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            fwlm_pkg::ST_CLEAR: o_cmd.clear_step = 1'b1;
            fwlm_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            fwlm_pkg::ST_DECODE: begin
                if (i_stat.action == fwlm_pkg::ACT_CHECK) begin
                    o_cmd.scan_init = 1'b1;
                end else if (!i_stat.idx_ok) begin
                    o_cmd.error_set = 1'b1;
                end
            end
            fwlm_pkg::ST_ER_READ:  o_cmd.erase_read  = 1'b1;
            fwlm_pkg::ST_ER_WRITE: o_cmd.erase_write = 1'b1;
            fwlm_pkg::ST_SCAN:     o_cmd.scan_read   = 1'b1;
            fwlm_pkg::ST_DRAIN:    ;
            fwlm_pkg::ST_CALC:     o_cmd.final_calc  = 1'b1;
            fwlm_pkg::ST_DONE:     o_done            = 1'b1;
            default:               ;
        endcase
    end

endmodule

### hdl/flash_wear_level_monitor_unit.sv
// Top level of the flash wear level monitor: controller, datapath and checks.
// Depends on fwlm_pkg, fwlm_ctrl, fwlm_dp and the defines header.
`include "flash_wear_level_monitor_unit_defines.svh"

// Keeps a 32-bit saturating erase counter per flash block in a 1024-entry
// memory. After reset the block sweeps the memory to zero, one entry a cycle,
// and holds busy high meanwhile; configuration writes are taken then too. An
// event is taken when start is high and busy is low. An erase is decoded, its
// counter read and the incremented value written before the result strobe; an
// index out of range strobes straight after decode. A check walks the
// effective block count through the single memory read port, one counter per
// cycle, then drains the last read and computes the result before the strobe.
// Each result is shown for exactly one cycle on o_result_strobe and cannot be
// held off; busy drops in the cycle after the strobe.
module flash_wear_level_monitor_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [fwlm_pkg::CNT_W-1:0]     i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_action,
    input  logic [fwlm_pkg::IDX_W-1:0]     i_block_index,
    output logic                           o_result_strobe,
    output logic [fwlm_pkg::CNT_W-1:0]     o_count_value,
    output logic [fwlm_pkg::CNT_W-1:0]     o_highest_count,
    output logic [fwlm_pkg::IDX_W-1:0]     o_coldest_block,
    output logic                           o_relocate_needed,
    output logic                           o_index_error
);

    fwlm_pkg::t_dp_cmd  cmd;
    fwlm_pkg::t_dp_stat stat;

    fwlm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_result_strobe)
    );

    fwlm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_block_index     (i_block_index),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_count_value     (o_count_value),
        .o_highest_count   (o_highest_count),
        .o_coldest_block   (o_coldest_block),
        .o_relocate_needed (o_relocate_needed),
        .o_index_error     (o_index_error)
    );

    // An accepted beat keeps the block busy in the next cycle
    `FWLM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // Strobe lasts one cycle
    `FWLM_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_result_strobe, !o_result_strobe)
    // A rejected erase reports no count and no check fields
    `FWLM_ASSERT_NOW(a_error_fields, i_clk, i_rst_n, o_result_strobe && o_index_error, (o_count_value == '0) && (o_highest_count == '0) && !o_relocate_needed)
    // Relocation implies a real spread between highest and lowest
    `FWLM_ASSERT_NOW(a_relocate_spread, i_clk, i_rst_n, o_result_strobe && o_relocate_needed, o_highest_count > o_count_value)

endmodule
